// ===== design/psc_pkg.sv =====
// Shared types and constants for the polyline collinear simplifier.
`timescale 1ns / 1ps
`default_nettype none
package psc_pkg;

    localparam int COORD_W   = 14;
    localparam int THR_W     = 24;
    localparam int Q_SHIFT   = 16;
    localparam logic [THR_W-1:0] THR_RESET = 24'd5898;

    // latency of the distance test pipeline and its drain counter width
    localparam int TEST_LAT  = 4;
    localparam int DRAIN_W   = 2;

    typedef struct packed {
        logic [COORD_W-1:0] vx;
        logic [COORD_W-1:0] vy;
        logic               in_last;
    } in_t;

    typedef struct packed {
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic               out_last;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_TEST   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage
`default_nettype wire

// ===== design/psc_cell.sv =====
// One run buffer cell: holds a vertex and passes it to its neighbor on shift.
`timescale 1ns / 1ps
`default_nettype none
module psc_cell #(
    parameter int COORD_BITS = 14
) (
    input  wire logic                  clk,
    input  wire logic                  shift,
    input  wire logic [COORD_BITS-1:0] din_x,
    input  wire logic [COORD_BITS-1:0] din_y,
    output logic      [COORD_BITS-1:0] x,
    output logic      [COORD_BITS-1:0] y
);

    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            x_reg <= din_x;
            y_reg <= din_y;
        end
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule
`default_nettype wire

// ===== design/psc_test.sv =====
// Pipelined perpendicular distance test of one run vertex per cycle.
`timescale 1ns / 1ps
`default_nettype none
module psc_test #(
    parameter int COORD_BITS = 14
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          valid,
    input  wire logic [COORD_BITS-1:0]         ax,
    input  wire logic [COORD_BITS-1:0]         ay,
    input  wire logic [COORD_BITS-1:0]         px,
    input  wire logic [COORD_BITS-1:0]         py,
    input  wire logic [COORD_BITS-1:0]         kx,
    input  wire logic [COORD_BITS-1:0]         ky,
    input  wire logic [psc_pkg::THR_W-1:0]     thr,
    output logic                               res_valid,
    output logic                               fail
);

    localparam int D  = COORD_BITS + 1;
    localparam int M  = 2 * D;
    localparam int H  = (M + 1) / 2;
    localparam int HI = M - H;
    localparam int CW = 2 * M + psc_pkg::Q_SHIFT;

    logic signed [D-1:0] dx, dy, ex, ey;

    logic signed [M-1:0] m1_reg, m2_reg, sx_reg, sy_reg;
    logic                v1_reg;

    logic signed [M:0]   cr;
    logic        [M:0]   cr_abs;
    logic        [M:0]   len_sum;
    logic        [M-1:0] ca_reg, len_reg;
    logic                v2_reg;

    logic [2*HI-1:0]               pa_reg;
    logic [HI+H-1:0]               pb_reg;
    logic [2*H-1:0]                pc_reg;
    logic [psc_pkg::THR_W+HI-1:0]  ra_reg;
    logic [psc_pkg::THR_W+H-1:0]   rb_reg;
    logic                          v3_reg;

    logic [CW-1:0] lhs_reg, rhs_reg;
    logic          v4_reg;

    assign dx = $signed({1'b0, px}) - $signed({1'b0, ax});
    assign dy = $signed({1'b0, py}) - $signed({1'b0, ay});
    assign ex = $signed({1'b0, kx}) - $signed({1'b0, ax});
    assign ey = $signed({1'b0, ky}) - $signed({1'b0, ay});

    assign cr      = {m1_reg[M-1], m1_reg} - {m2_reg[M-1], m2_reg};
    assign cr_abs  = cr[M] ? (~cr + 1'b1) : cr;
    assign len_sum = {1'b0, sx_reg} + {1'b0, sy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg  <= dx * ey;
        m2_reg  <= dy * ex;
        sx_reg  <= dx * dx;
        sy_reg  <= dy * dy;

        // magnitudes fit M bits
        ca_reg  <= cr_abs[M-1:0];
        len_reg <= len_sum[M-1:0];

        // split the square and the threshold product into half-width partial products
        pa_reg  <= ca_reg[M-1:H] * ca_reg[M-1:H];
        pb_reg  <= ca_reg[M-1:H] * ca_reg[H-1:0];
        pc_reg  <= ca_reg[H-1:0] * ca_reg[H-1:0];
        ra_reg  <= thr * len_reg[M-1:H];
        rb_reg  <= thr * len_reg[H-1:0];

        lhs_reg <= ((CW'(pa_reg) << (2 * H)) + (CW'(pb_reg) << (H + 1)) + CW'(pc_reg))
                   << psc_pkg::Q_SHIFT;
        rhs_reg <= (CW'(ra_reg) << H) + CW'(rb_reg);
    end

    assign res_valid = v4_reg;
    assign fail      = v4_reg & (lhs_reg > rhs_reg);

endmodule
`default_nettype wire

// ===== design/polyline_collinear_simplifier_unit.sv =====
// Top level: anchor, run cell chain, distance test sequencer and output queue.
//
//  channel | direction | payload            | handshake
//  --------+-----------+--------------------+-------------------
//  in      | input     | psc_pkg::in_t      | in_valid / in_stall
//  out     | output    | psc_pkg::out_t     | out_valid / out_stall
//  cfg     | input     | threshold (24 bit) | cfg_we
//
// A vertex with a nonempty, non-full run is tested in full: the run
// ring rotates once through the shared test pipeline (one vertex a cycle),
// then the 4-stage pipeline drains and the FINISH state commits. Other
// vertices skip the ring. Results go to a 4-entry queue; a request is taken
// when idle with at most two results queued. Reset needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module polyline_collinear_simplifier_unit #(
    parameter int MAX_RUN    = 64,
    parameter int COORD_BITS = 14
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire psc_pkg::in_t                  in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output psc_pkg::out_t                      out_data,
    input  wire logic                          cfg_we,
    input  wire logic [psc_pkg::THR_W-1:0]     cfg_data
);

    localparam int C   = COORD_BITS;
    localparam int SW  = (MAX_RUN > 2) ? $clog2(MAX_RUN) : 1;
    localparam int CNW = $clog2(MAX_RUN + 1);
    localparam int CW  = psc_pkg::COORD_W;

    psc_pkg::state_t state_reg, state_next;

    logic [psc_pkg::THR_W-1:0] thr_reg;
    logic [C-1:0]   ax_reg, ay_reg, ax_next, ay_next;
    logic [C-1:0]   px_reg, py_reg, px_next, py_next;
    logic           plast_reg, plast_next;
    logic           have_reg, have_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0]  step_reg, step_next;
    logic [psc_pkg::DRAIN_W-1:0] drain_reg, drain_next;
    logic           fail_reg, fail_next;

    logic [C-1:0]   in_x, in_y;
    logic [CW-1:0]  px_o, py_o, ax_o, ay_o;
    logic [CW-1:0]  c0x_o, c0y_o;

    logic [C-1:0]   cx [MAX_RUN];
    logic [C-1:0]   cy [MAX_RUN];
    logic [C-1:0]   c0_din_x, c0_din_y;
    logic           shift;
    logic           tvalid;
    logic           t_res_valid, t_fail;
    logic           accept;

    // output queue
    psc_pkg::out_t  q_mem [4];
    logic [1:0]     q_wr_reg, q_rd_reg;
    logic [2:0]     q_cnt_reg;
    logic           push0, push1, pop;
    psc_pkg::out_t  d0, d1;

    generate
        if (C >= CW)
        begin : g_wide
            assign in_x  = C'(in_data.vx);
            assign in_y  = C'(in_data.vy);
            assign px_o  = px_reg[CW-1:0];
            assign py_o  = py_reg[CW-1:0];
            assign ax_o  = cx[0][CW-1:0];
            assign ay_o  = cy[0][CW-1:0];
        end
        else
        begin : g_narrow
            assign in_x  = in_data.vx[C-1:0];
            assign in_y  = in_data.vy[C-1:0];
            assign px_o  = CW'(px_reg);
            assign py_o  = CW'(py_reg);
            assign ax_o  = CW'(cx[0]);
            assign ay_o  = CW'(cy[0]);
        end
    endgenerate

    assign c0x_o = ax_o;
    assign c0y_o = ay_o;

    assign in_stall = !((state_reg == psc_pkg::ST_IDLE) && (q_cnt_reg <= 3'd2));
    assign accept   = in_valid & ~in_stall;

    // run ring: cell 0 holds the newest vertex
    assign shift    = (state_reg == psc_pkg::ST_TEST) || (state_reg == psc_pkg::ST_FINISH);
    assign c0_din_x = (state_reg == psc_pkg::ST_TEST) ? cx[MAX_RUN-1] : px_reg;
    assign c0_din_y = (state_reg == psc_pkg::ST_TEST) ? cy[MAX_RUN-1] : py_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RUN; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                psc_cell #(.COORD_BITS(C)) u_cell (
                    .clk   (clk),
                    .shift (shift),
                    .din_x (c0_din_x),
                    .din_y (c0_din_y),
                    .x     (cx[gi]),
                    .y     (cy[gi])
                );
            end
            else
            begin : g_body
                psc_cell #(.COORD_BITS(C)) u_cell (
                    .clk   (clk),
                    .shift (shift),
                    .din_x (cx[gi-1]),
                    .din_y (cy[gi-1]),
                    .x     (cx[gi]),
                    .y     (cy[gi])
                );
            end
        end
    endgenerate

    // the tail cell holds original entry MAX_RUN-1-step; valid when below count
    assign tvalid = (state_reg == psc_pkg::ST_TEST) &&
                    (({1'b0, CNW'(step_reg)} + {1'b0, cnt_reg}) >= (CNW+1)'(MAX_RUN));

    psc_test #(.COORD_BITS(C)) u_test (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (tvalid),
        .ax        (ax_reg),
        .ay        (ay_reg),
        .px        (px_reg),
        .py        (py_reg),
        .kx        (cx[MAX_RUN-1]),
        .ky        (cy[MAX_RUN-1]),
        .thr       (thr_reg),
        .res_valid (t_res_valid),
        .fail      (t_fail)
    );

    always_comb
    begin
        state_next = state_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        plast_next = plast_reg;
        have_next  = have_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        drain_next = drain_reg;
        fail_next  = fail_reg | (t_res_valid & t_fail);
        push0      = 1'b0;
        push1      = 1'b0;
        d0         = '0;
        d1         = '0;

        unique case (state_reg)
            psc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    px_next    = in_x;
                    py_next    = in_y;
                    plast_next = in_data.in_last;
                    step_next  = '0;
                    drain_next = '0;
                    if (!have_reg)
                    begin
                        push0       = 1'b1;
                        d0.ox       = in_data.vx;
                        d0.oy       = in_data.vy;
                        d0.out_last = in_data.in_last;
                        if (C < CW)
                        begin
                            d0.ox = CW'(in_x);
                            d0.oy = CW'(in_y);
                        end
                        cnt_next = '0;
                        if (!in_data.in_last)
                        begin
                            ax_next   = in_x;
                            ay_next   = in_y;
                            have_next = 1'b1;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        fail_next  = 1'b0;
                        state_next = psc_pkg::ST_FINISH;
                    end
                    else if (cnt_reg == CNW'(MAX_RUN))
                    begin
                        fail_next  = 1'b1;
                        state_next = psc_pkg::ST_FINISH;
                    end
                    else
                    begin
                        fail_next  = 1'b0;
                        state_next = psc_pkg::ST_TEST;
                    end
                end
            end
            psc_pkg::ST_TEST:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(MAX_RUN - 1))
                begin
                    state_next = psc_pkg::ST_DRAIN;
                end
            end
            psc_pkg::ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == psc_pkg::DRAIN_W'(psc_pkg::TEST_LAT - 1))
                begin
                    state_next = psc_pkg::ST_FINISH;
                end
            end
            psc_pkg::ST_FINISH:
            begin
                state_next = psc_pkg::ST_IDLE;
                if (!fail_reg)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    // break: newest run vertex becomes the anchor
                    ax_next     = cx[0];
                    ay_next     = cy[0];
                    push0       = 1'b1;
                    d0.ox       = c0x_o;
                    d0.oy       = c0y_o;
                    d0.out_last = 1'b0;
                    cnt_next    = CNW'(1);
                end
                if (plast_reg)
                begin
                    have_next = 1'b0;
                    cnt_next  = '0;
                    if (fail_reg)
                    begin
                        push1       = 1'b1;
                        d1.ox       = px_o;
                        d1.oy       = py_o;
                        d1.out_last = 1'b1;
                    end
                    else
                    begin
                        push0       = 1'b1;
                        d0.ox       = px_o;
                        d0.oy       = py_o;
                        d0.out_last = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = psc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psc_pkg::ST_IDLE;
            thr_reg   <= psc_pkg::THR_RESET;
            ax_reg    <= '0;
            ay_reg    <= '0;
            have_reg  <= 1'b0;
            cnt_reg   <= '0;
            step_reg  <= '0;
            drain_reg <= '0;
            fail_reg  <= 1'b0;
            plast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            have_reg  <= have_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            drain_reg <= drain_next;
            fail_reg  <= fail_next;
            plast_reg <= plast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
    end

    // output queue
    assign pop       = out_valid & ~out_stall;
    assign out_valid = (q_cnt_reg != 3'd0);
    assign out_data  = q_mem[q_rd_reg];

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            q_mem[q_wr_reg] <= d0;
        end
        if (push1)
        begin
            q_mem[q_wr_reg + 2'd1] <= d1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            q_wr_reg  <= q_wr_reg + {1'b0, push0} + {1'b0, push1};
            q_rd_reg  <= q_rd_reg + {1'b0, pop};
            q_cnt_reg <= q_cnt_reg + {2'b0, push0} + {2'b0, push1} - {2'b0, pop};
        end
    end

endmodule
`default_nettype wire
